/* rtl/core/replay_window_check_macros.svh */
// Assertion macros for the replay window checker.
// Included by the top level; no other dependencies.
`ifndef REPLAY_WINDOW_CHECK_MACROS_SVH
`define REPLAY_WINDOW_CHECK_MACROS_SVH

`ifndef SYNTHESIS
`define RWC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("replay_window_check assertion failed");
`define RWC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("replay_window_check assertion failed");
`else
`define RWC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RWC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

/* rtl/core/rwc_pkg.sv */
// Shared constants, codes and types of the replay window checker.
// No dependencies.
package rwc_pkg;

  localparam int IDX_W       = 48;
  localparam int WINDOW_BITS = 1024;
  localparam int WIN_AW      = $clog2(WINDOW_BITS);
  localparam int ROW_W       = 32;
  localparam int ROW_AW      = $clog2(ROW_W);
  localparam int ROWS        = WINDOW_BITS / ROW_W;
  localparam int ROW_SEL_W   = WIN_AW - ROW_AW;
  localparam int CNT_W       = ROW_SEL_W + 1;

  localparam logic [1:0] OP_CHECK      = 2'd0;
  localparam logic [1:0] OP_CHECK_MARK = 2'd1;
  localparam logic [1:0] OP_MARK       = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_OLD  = 2'd1;
  localparam logic [1:0] STATUS_REPLAYED = 2'd2;

  typedef struct packed {
    logic             neg;
    logic             far;
  } sub_res_t;

endpackage

/* rtl/core/rwc_sub.sv */
// Shared 48-bit subtract and window-distance compare.
// Depends on rwc_pkg.
module rwc_sub (
  input  logic [rwc_pkg::IDX_W-1:0] a_i,
  input  logic [rwc_pkg::IDX_W-1:0] b_i,
  output rwc_pkg::sub_res_t         res_o
);
  import rwc_pkg::*;

  logic [IDX_W:0] full;

  assign full       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.neg  = full[IDX_W];
  assign res_o.far  = |full[IDX_W-1:WIN_AW];

endmodule

/* rtl/core/rwc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rwc_ram #(
  parameter int DW = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/replay_window_check.sv */
// Sliding-window anti-replay checker, top level. Uses rwc_pkg, rwc_sub, rwc_ram.
// Steps: S_EVAL, then S_FIN, which raises out_valid once the output register is free;
// an advance passes S_GAP and sweeps up to ROWS+1 bitmap rows in S_ROW_RD/S_ROW_WR,
// and a jump of a full window or more clears the other row valid bits in S_GAP instead.
// A new transaction is taken only in S_IDLE, once the last one has left S_FIN.
// Reset (sync, active low): highest index and row valid bits clear at once.
`include "replay_window_check_macros.svh"

module replay_window_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [rwc_pkg::IDX_W-1:0] in_packet_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status
);
  import rwc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_GAP,
    S_ROW_RD,
    S_ROW_WR,
    S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     h_r, h_nxt;
  logic [ROWS-1:0]      row_valid_r, row_valid_nxt;
  logic                 vq_r, vq_nxt;
  logic [ROW_SEL_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [ROW_AW-1:0]    lo_r, lo_nxt;
  logic                 first_r, first_nxt;
  logic [1:0]           res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;

  logic [IDX_W-1:0]     sub_a, sub_b;
  sub_res_t             sub_res;
  logic                 ram_we;
  logic [ROW_SEL_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata;

  logic [ROW_W-1:0]     row_data, bit_onehot, clr_mask;
  logic [ROW_AW-1:0]    bit_pos, lo, hi;
  logic [ROW_SEL_W-1:0] idx_row;
  logic [1:0]           chk;
  logic                 mark, last, h_carry, fin_go;

  rwc_sub u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  rwc_ram #(
    .DW (ROW_W),
    .AW (ROW_SEL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  assign bit_pos    = idx_r[ROW_AW-1:0];
  assign idx_row    = idx_r[WIN_AW-1:ROW_AW];
  assign bit_onehot = ROW_W'(1) << bit_pos;
  assign row_data   = vq_r ? ram_rdata : '0;
  assign h_carry    = (h_r[ROW_AW-1:0] == '1);
  assign last       = (rem_r == '0);
  assign fin_go     = (state_r == S_FIN) && !(out_valid_r && out_stall);

  assign sub_a = (state_r == S_EVAL) ? h_r : idx_r;
  assign sub_b = (state_r == S_EVAL) ? idx_r : h_r;

  assign ram_raddr = (state_r == S_IDLE) ? in_packet_index[WIN_AW-1:ROW_AW] : row_r;
  assign vq_nxt    = row_valid_r[ram_raddr];

  always_comb begin
    if (sub_res.neg) begin
      chk = STATUS_OK;
    end else if (sub_res.far) begin
      chk = STATUS_TOO_OLD;
    end else if (row_data[bit_pos]) begin
      chk = STATUS_REPLAYED;
    end else begin
      chk = STATUS_OK;
    end
  end

  always_comb begin
    lo = first_r ? lo_r : '0;
    hi = last ? bit_pos : '1;
    for (int j = 0; j < ROW_W; j++) begin
      clr_mask[j] = (ROW_AW'(j) >= lo) && (ROW_AW'(j) <= hi);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    h_nxt          = h_r;
    row_valid_nxt  = row_valid_r;
    row_nxt        = row_r;
    rem_nxt        = rem_r;
    lo_nxt         = lo_r;
    first_nxt      = first_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_row;
    ram_wdata      = row_data | bit_onehot;
    mark           = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          idx_nxt   = in_packet_index;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (op_r)
          OP_MARK: begin
            mark    = 1'b1;
            res_nxt = STATUS_OK;
          end
          OP_CHECK_MARK: begin
            mark    = (chk == STATUS_OK);
            res_nxt = chk;
          end
          default: begin
            res_nxt = chk;
          end
        endcase
        if (mark && sub_res.neg) begin
          state_nxt = S_GAP;
        end else begin
          if (mark && !sub_res.far) begin
            ram_we                 = 1'b1;
            row_valid_nxt[idx_row] = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_GAP: begin
        if (sub_res.far) begin
          row_valid_nxt          = '0;
          row_valid_nxt[idx_row] = 1'b1;
          ram_we                 = 1'b1;
          ram_wdata              = bit_onehot;
          h_nxt                  = idx_r;
          state_nxt              = S_FIN;
        end else begin
          row_nxt   = h_r[WIN_AW-1:ROW_AW] + ROW_SEL_W'(h_carry);
          rem_nxt   = idx_r[WIN_AW:ROW_AW] - h_r[WIN_AW:ROW_AW] - CNT_W'(h_carry);
          lo_nxt    = h_r[ROW_AW-1:0] + ROW_AW'(1);
          first_nxt = 1'b1;
          state_nxt = S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        state_nxt = S_ROW_WR;
      end
      S_ROW_WR: begin
        ram_we               = 1'b1;
        ram_waddr            = row_r;
        ram_wdata            = (row_data & ~clr_mask) | (last ? bit_onehot : '0);
        row_valid_nxt[row_r] = 1'b1;
        row_nxt              = row_r + ROW_SEL_W'(1);
        rem_nxt              = rem_r - CNT_W'(1);
        first_nxt            = 1'b0;
        if (last) begin
          h_nxt     = idx_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ROW_RD;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r         <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    vq_r         <= vq_nxt;
    row_r        <= row_nxt;
    rem_r        <= rem_nxt;
    lo_r         <= lo_nxt;
    first_r      <= first_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
  end

  `RWC_ASSERT_NEXT(a_accept_eval, clk, rst_n, in_valid && !in_stall, state_r == S_EVAL)
  `RWC_ASSERT_NEXT(a_highest_mono, clk, rst_n, 1'b1, h_r >= $past(h_r))
  `RWC_ASSERT_IMP(a_rem_range, clk, rst_n, state_r == S_ROW_WR, rem_r <= CNT_W'(ROWS))
  `RWC_ASSERT_NEXT(a_fin_out, clk, rst_n, fin_go, out_valid && state_r == S_IDLE)

endmodule

/* tb/sv/rwc_status_checker.sv */
// Status checker for replay_window_check: predicts the status of every accepted
// transaction and compares it with the result channel. Depends on rwc_pkg.
module rwc_status_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [rwc_pkg::IDX_W-1:0] in_packet_index,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                out_status,
  output int                        fail_count,
  output int                        pending
);
  import rwc_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [1:0]       status;
  } status_due_t;

  logic [IDX_W-1:0] top_index;
  logic             seen_map [WINDOW_BITS];
  status_due_t      status_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [1:0] classify(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] lag;
    if (idx > top_index) return STATUS_OK;
    lag = top_index - idx;
    if (lag >= WINDOW_BITS) return STATUS_TOO_OLD;
    if (seen_map[lag[WIN_AW-1:0]]) return STATUS_REPLAYED;
    return STATUS_OK;
  endfunction

  function automatic void record(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] gap;
    logic [IDX_W-1:0] lag;
    int               g;
    if (idx > top_index) begin
      gap = idx - top_index;
      if (gap >= WINDOW_BITS) begin
        seen_map = '{default: 1'b0};
      end else begin
        g = int'(gap);
        for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
          if (i >= g) seen_map[i] = seen_map[i-g];
          else seen_map[i] = 1'b0;
        end
      end
      seen_map[0] = 1'b1;
      top_index = idx;
    end else begin
      lag = top_index - idx;
      if (lag < WINDOW_BITS) seen_map[lag[WIN_AW-1:0]] = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : track
    status_due_t want;
    if (!rst_n) begin
      top_index = '0;
      seen_map = '{default: 1'b0};
      status_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transaction: status %0d with nothing outstanding", out_status);
        end else begin
          want = status_due.pop_front();
          if (out_status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("status mismatch for index 0x%012h: expected %0d, got %0d",
                       want.idx, want.status, out_status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.idx = in_packet_index;
        if (in_op == OP_MARK) begin
          record(in_packet_index);
          want.status = STATUS_OK;
        end else begin
          // any other code, the unused one too, checks first
          want.status = classify(in_packet_index);
          if (in_op == OP_CHECK_MARK && want.status == STATUS_OK) record(in_packet_index);
        end
        status_due.push_back(want);
      end
    end
    pending = status_due.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for replay_window_check: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on rwc_pkg and rwc_status_checker.
module tb_top;
  import rwc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 535;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN       = 100;
  localparam int QUIET_LIMIT = 3000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_op;
  logic [IDX_W-1:0] in_packet_index;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;

  int               fail_count;
  int               pending;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               hold_left;
  int               quiet;
  logic             long_hold_req;
  logic [IDX_W-1:0] front;

  replay_window_check uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_packet_index (in_packet_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status)
  );

  rwc_status_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_packet_index (in_packet_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_packet_index <= idx;
    do @(posedge clk); while (in_stall);
    if ((op == OP_CHECK_MARK || op == OP_MARK) && idx > front) front = idx;
    @(negedge clk);
  endtask

  task automatic random_item();
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [63:0]      wide;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 25) op = OP_CHECK;
    else if (r < 65) op = OP_CHECK_MARK;
    else if (r < 90) op = OP_MARK;
    else op = OP_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 35) idx = front + $urandom_range(1, 40);
    else if (r < 40) idx = front + $urandom_range(41, 1100);
    else if (r < 43) idx = front + $urandom_range(1101, 1 << 20);
    else if (r < 78) idx = front - $urandom_range(0, 1023);
    else if (r < 88) idx = front - $urandom_range(1020, 1030);
    else if (r < 95) idx = front - $urandom_range(1031, 1 << 16);
    else begin
      // arbitrary index, checked only so the window stays usable
      wide = {$urandom(), $urandom()};
      idx = wide[IDX_W-1:0];
      op = r[0] ? OP_CHECK : OP_UNUSED;
    end
    send_item(op, idx);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_CHECK;
    in_packet_index = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b0;
    front = '0;
    quiet = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_CHECK, 48'd0);
    send_item(OP_CHECK_MARK, 48'd0);
    send_item(OP_CHECK, 48'd0);
    send_item(OP_CHECK_MARK, 48'd0);
    send_item(OP_UNUSED, 48'd0);
    send_item(OP_MARK, 48'd5);
    send_item(OP_CHECK, 48'd0);
    send_item(OP_CHECK_MARK, 48'd1029);
    send_item(OP_CHECK, 48'd5);
    send_item(OP_CHECK, 48'd6);
    send_item(OP_MARK, 48'd6);
    send_item(OP_CHECK, 48'd6);
    send_item(OP_MARK, 48'd4);
    send_item(OP_CHECK, 48'd4);
    send_item(OP_CHECK_MARK, 48'd2052);
    send_item(OP_CHECK, 48'd1029);
    send_item(OP_CHECK, 48'd6);
    send_item(OP_CHECK, 48'hFFFF_FFFF_FFFF);
    send_item(OP_UNUSED, 48'hFFFF_FFFF_FFFF);
    send_item(OP_CHECK_MARK, 48'h5555_5555_5555);
    send_item(OP_CHECK, 48'd2052);
    send_item(OP_MARK, 48'h5555_5555_5554);
    send_item(OP_CHECK, 48'h5555_5555_5554);
    send_item(OP_CHECK_MARK, 48'h5555_5555_5555);

    send_idle_pct = 31;
    recv_idle_pct = 57;
    repeat (PHASE_ITEMS) random_item();
    send_idle_pct = 57;
    recv_idle_pct = 31;
    repeat (PHASE_ITEMS) random_item();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    repeat (PHASE_ITEMS) random_item();
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
